### sv/mlnp_pkg.sv
package mlnp_pkg;

  localparam int CHANNELS   = 16;
  localparam int NOTES      = 128;
  localparam int STAMP_BITS = 32;

  localparam int ENTRIES = CHANNELS * NOTES;
  localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NOTE_W  = (NOTES > 1) ? $clog2(NOTES) : 1;

  localparam int FUNC_W = 3;
  localparam int CHAN_W = 4;
  localparam int KEY_W  = 7;
  localparam int AMT_W  = 7;
  localparam int ACT_W  = 2;

  localparam int PEDAL_THRESHOLD = 64;

  localparam logic [FUNC_W-1:0] FN_NOTE_ON  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_NOTE_OFF = 3'd1;
  localparam logic [FUNC_W-1:0] FN_ALL_OFF  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_PEDAL    = 3'd3;
  localparam logic [FUNC_W-1:0] FN_PANIC    = 3'd4;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE,
    ACT_TRIGGER,
    ACT_RELEASE,
    ACT_SILENCE
  } act_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_NOTE_ON,
    OP_NOTE_OFF,
    OP_ALL_OFF,
    OP_PEDAL_UP,
    OP_PEDAL_DOWN,
    OP_PANIC,
    OP_INIT
  } op_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_DECODE,
    U_SETUP,
    U_SWEEP,
    U_DRAIN,
    U_VREAD,
    U_REPORT
  } upc_t;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_WAIT_IN,
    JC_IF_SKIP,
    JC_IF_MORE,
    JC_WAIT_OUT
  } jc_t;

  typedef struct packed {
    logic ready;
    logic setup;
    logic sweep;
    logic vread;
    logic report;
    jc_t  jc;
    upc_t target;
  } ctrl_t;

  typedef struct packed {
    logic                  held;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  function automatic ctrl_t ucode(upc_t pc);
    ctrl_t c;
    c = '0;
    unique case (pc)
      U_IDLE: begin
        c.ready  = 1'b1;
        c.jc     = JC_WAIT_IN;
        c.target = U_IDLE;
      end
      U_DECODE: begin
        c.jc     = JC_IF_SKIP;
        c.target = U_REPORT;
      end
      U_SETUP: begin
        c.setup = 1'b1;
        c.jc    = JC_NEXT;
      end
      U_SWEEP: begin
        c.sweep  = 1'b1;
        c.jc     = JC_IF_MORE;
        c.target = U_SWEEP;
      end
      U_DRAIN: begin
        c.jc = JC_NEXT;
      end
      U_VREAD: begin
        c.vread = 1'b1;
        c.jc    = JC_NEXT;
      end
      U_REPORT: begin
        c.report = 1'b1;
        c.jc     = JC_WAIT_OUT;
        c.target = U_IDLE;
      end
      default: begin
        c.jc     = JC_WAIT_OUT;
        c.target = U_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

### sv/mlnp_if.sv
interface mlnp_in_if import mlnp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CHAN_W-1:0] chan;
  logic [KEY_W-1:0]  key_number;
  logic [AMT_W-1:0]  amount;

  modport source (output valid, output func, output chan, output key_number,
                  output amount, input ready);
  modport sink (input valid, input func, input chan, input key_number,
                input amount, output ready);
endinterface

interface mlnp_out_if import mlnp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [KEY_W-1:0]  out_note;
  logic [AMT_W-1:0]  out_velocity;
  logic [CHAN_W-1:0] out_channel;

  modport source (output valid, output action, output out_note, output out_velocity,
                  output out_channel, input ready);
  modport sink (input valid, input action, input out_note, input out_velocity,
                input out_channel, output ready);
endinterface

### sv/mono_last_note_priority_unit.sv
// Monophonic last-note-priority selector with a sustain pedal per channel. Each accepted
// request (note on, note off, all notes off, pedal, panic) gives exactly one result. The
// block takes a request only while its sequencer is idle. A request that sweeps the note
// table runs over all ENTRIES entries (2048 at 16 channels by 128 notes) in the entry
// memory, which is read, updated and compared one entry per cycle. Pedal press, ignored
// notes and unused codes skip the sweep and go from decode straight to the report step.
// Panic and reset both run a clearing sweep over all entries; after reset the first
// request is accepted only once that sweep has finished. A finished result waits in an
// output register, and the next request is taken while it waits.
module mono_last_note_priority_unit import mlnp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  mlnp_in_if.sink    in_req,
  mlnp_out_if.source out_rsp
);

  ctrl_t ctrl;
  upc_t  upc_r, upc_nxt;

  logic              accept;
  logic [CH_W-1:0]   ch_in;
  logic [NOTE_W-1:0] note_in;
  logic [ADDR_W-1:0] idx_in;
  logic              key_ok;
  op_t               op_in;

  op_t               op_r;
  logic [CH_W-1:0]   ev_ch_r;
  logic [ADDR_W-1:0] ev_idx_r;

  logic                  pedal_r [CHANNELS];
  logic [STAMP_BITS-1:0] stamp_cnt_r;

  entry_t            st_mem [ENTRIES];
  logic [AMT_W-1:0]  vel_mem [ENTRIES];

  logic [ADDR_W-1:0] sweep_addr_r;
  logic [CH_W-1:0]   sweep_ch_r;
  logic [NOTE_W-1:0] sweep_note_r;

  logic              p_valid_r;
  logic [ADDR_W-1:0] p_addr_r;
  logic [CH_W-1:0]   p_ch_r;
  entry_t            st_rd_r;
  entry_t            st_new;

  logic [STAMP_BITS-1:0] best_r;
  logic                  found_r;
  logic [ADDR_W-1:0]     best_addr_r;
  logic [CH_W-1:0]       best_ch_r;
  logic [NOTE_W-1:0]     best_note_r;
  logic [AMT_W-1:0]      vel_rd_r;

  logic              chosen_valid_r;
  logic [ADDR_W-1:0] chosen_addr_r;

  logic              out_valid_r;
  act_t              out_action_r;
  logic [KEY_W-1:0]  out_note_r;
  logic [AMT_W-1:0]  out_velocity_r;
  logic [CHAN_W-1:0] out_channel_r;

  logic out_free;
  logic changed;
  logic swept_op;
  logic report_load;
  act_t act_c;

  assign ctrl         = ucode(upc_r);
  assign in_req.ready = ctrl.ready;
  assign accept       = in_req.valid && in_req.ready;

  assign ch_in   = (int'(in_req.chan) >= CHANNELS) ? CH_W'(CHANNELS - 1) : CH_W'(in_req.chan);
  assign note_in = NOTE_W'(in_req.key_number);
  assign key_ok  = int'(in_req.key_number) < NOTES;
  assign idx_in  = ADDR_W'(int'(ch_in) * NOTES + int'(note_in));

  always_comb begin
    op_in = OP_NONE;
    unique case (in_req.func)
      FN_NOTE_ON: begin
        if (!key_ok) begin
          op_in = OP_NONE;
        end else if (in_req.amount == '0) begin
          op_in = OP_NOTE_OFF;
        end else begin
          op_in = OP_NOTE_ON;
        end
      end
      FN_NOTE_OFF: op_in = key_ok ? OP_NOTE_OFF : OP_NONE;
      FN_ALL_OFF:  op_in = OP_ALL_OFF;
      FN_PEDAL: begin
        op_in = (int'(in_req.amount) >= PEDAL_THRESHOLD) ? OP_PEDAL_DOWN : OP_PEDAL_UP;
      end
      FN_PANIC:    op_in = OP_PANIC;
      default:     op_in = OP_NONE;
    endcase
  end

  assign out_free = !out_valid_r || out_rsp.ready;

  always_comb begin
    upc_nxt = upc_r;
    unique case (ctrl.jc)
      JC_NEXT:     upc_nxt = upc_t'(upc_r + 3'd1);
      JC_WAIT_IN:  upc_nxt = accept ? upc_t'(upc_r + 3'd1) : upc_r;
      JC_IF_SKIP: begin
        upc_nxt = (op_r == OP_NONE || op_r == OP_PEDAL_DOWN) ? ctrl.target
                                                             : upc_t'(upc_r + 3'd1);
      end
      JC_IF_MORE: begin
        upc_nxt = (sweep_addr_r != ADDR_W'(ENTRIES - 1)) ? ctrl.target
                                                         : upc_t'(upc_r + 3'd1);
      end
      JC_WAIT_OUT: upc_nxt = (out_free || op_r == OP_INIT) ? ctrl.target : upc_r;
      default:     upc_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= U_SETUP;
      op_r        <= OP_INIT;
      stamp_cnt_r <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        pedal_r[c] <= 1'b0;
      end
    end else begin
      upc_r <= upc_nxt;
      if (accept) begin
        op_r <= op_in;
        unique case (op_in)
          OP_PANIC: begin
            stamp_cnt_r <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
              pedal_r[c] <= 1'b0;
            end
          end
          OP_NOTE_ON: begin
            if (stamp_cnt_r != '1) begin
              stamp_cnt_r <= stamp_cnt_r + 1'b1;
            end
          end
          OP_PEDAL_DOWN: pedal_r[ch_in] <= 1'b1;
          OP_PEDAL_UP:   pedal_r[ch_in] <= 1'b0;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ev_ch_r  <= ch_in;
      ev_idx_r <= idx_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.setup) begin
      sweep_addr_r <= '0;
      sweep_ch_r   <= '0;
      sweep_note_r <= '0;
    end else if (ctrl.sweep) begin
      sweep_addr_r <= sweep_addr_r + 1'b1;
      if (sweep_note_r == NOTE_W'(NOTES - 1)) begin
        sweep_note_r <= '0;
        sweep_ch_r   <= sweep_ch_r + 1'b1;
      end else begin
        sweep_note_r <= sweep_note_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= ctrl.sweep;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sweep) begin
      st_rd_r  <= st_mem[sweep_addr_r];
      p_addr_r <= sweep_addr_r;
      p_ch_r   <= sweep_ch_r;
    end
    if (p_valid_r) begin
      st_mem[p_addr_r] <= st_new;
    end
  end

  always_comb begin
    st_new = st_rd_r;
    unique case (op_r)
      OP_INIT, OP_PANIC: st_new = '0;
      OP_NOTE_ON: begin
        if (p_addr_r == ev_idx_r) begin
          st_new.held  = 1'b1;
          st_new.stamp = stamp_cnt_r;
        end
      end
      OP_NOTE_OFF: begin
        if (p_addr_r == ev_idx_r) begin
          st_new.held = 1'b0;
          if (!pedal_r[ev_ch_r]) begin
            st_new.stamp = '0;
          end
        end
      end
      OP_ALL_OFF: begin
        if (p_ch_r == ev_ch_r) begin
          st_new.held = 1'b0;
          if (!pedal_r[ev_ch_r]) begin
            st_new.stamp = '0;
          end
        end
      end
      OP_PEDAL_UP: begin
        if (p_ch_r == ev_ch_r && !st_rd_r.held) begin
          st_new.stamp = '0;
        end
      end
      default: st_new = st_rd_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      best_r  <= '0;
    end else if (ctrl.setup) begin
      found_r <= 1'b0;
      best_r  <= '0;
    end else if (p_valid_r && st_new.stamp > best_r) begin
      found_r <= 1'b1;
      best_r  <= st_new.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.setup) begin
      best_addr_r <= '0;
      best_ch_r   <= '0;
      best_note_r <= '0;
    end else if (p_valid_r && st_new.stamp > best_r) begin
      best_addr_r <= p_addr_r;
      best_ch_r   <= p_ch_r;
      best_note_r <= NOTE_W'(int'(p_addr_r) - int'(p_ch_r) * NOTES);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op_in == OP_NOTE_ON) begin
      vel_mem[idx_in] <= in_req.amount;
    end
    if (ctrl.vread) begin
      vel_rd_r <= vel_mem[best_addr_r];
    end
  end

  assign changed  = (found_r != chosen_valid_r) || (found_r && best_addr_r != chosen_addr_r);
  assign swept_op = (op_r != OP_NONE) && (op_r != OP_PEDAL_DOWN) && (op_r != OP_INIT);
  assign report_load = ctrl.report && out_free && (op_r != OP_INIT);

  always_comb begin
    act_c = ACT_NONE;
    unique case (op_r)
      OP_NOTE_ON: act_c = ACT_TRIGGER;
      OP_PANIC:   act_c = ACT_SILENCE;
      OP_NOTE_OFF, OP_ALL_OFF, OP_PEDAL_UP: begin
        if (!changed) begin
          act_c = ACT_NONE;
        end else if (found_r) begin
          act_c = ACT_TRIGGER;
        end else begin
          act_c = ACT_RELEASE;
        end
      end
      default: act_c = ACT_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chosen_valid_r <= 1'b0;
      chosen_addr_r  <= '0;
    end else if (report_load && swept_op) begin
      chosen_valid_r <= found_r;
      chosen_addr_r  <= found_r ? best_addr_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (report_load) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (report_load) begin
      out_action_r <= act_c;
      if (act_c == ACT_TRIGGER) begin
        out_note_r     <= KEY_W'(best_note_r);
        out_velocity_r <= vel_rd_r;
        out_channel_r  <= CHAN_W'(best_ch_r);
      end else begin
        out_note_r     <= '0;
        out_velocity_r <= '0;
        out_channel_r  <= '0;
      end
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.action       = out_action_r;
  assign out_rsp.out_note     = out_note_r;
  assign out_rsp.out_velocity = out_velocity_r;
  assign out_rsp.out_channel  = out_channel_r;

`ifndef SYNTH
  a_sweep_step: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r == U_SWEEP && $past(upc_r) == U_SWEEP) |->
      sweep_addr_r == ADDR_W'($past(sweep_addr_r) + 1'b1))
    else $error("sweep address skipped an entry");

  a_result_from_report: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |=> (!out_valid_r || $past(upc_r) == U_REPORT))
    else $error("result appeared outside the report step");

  a_stamp_only_on_request: assert property (@(posedge clk) disable iff (!rst_n)
    (upc_r != U_IDLE) |=> stamp_cnt_r == $past(stamp_cnt_r))
    else $error("stamp counter moved without an accepted request");
`endif

endmodule
